FILE: rtl/rtaq_pkg.sv
// Shared types, constants and the HSL palette table for the RGBA to 256-color quantizer.
// No dependencies; every other file in rtl/ imports this package.
package rtaq_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int CELL_BITS    = 4;
	localparam int STEP_BITS    = 4;
	localparam int NUM_CELLS    = 1 << CELL_BITS;
	localparam int DIST_BITS    = 18;
	localparam int DIVN_BITS    = 15;

	// one palette color in integer HSL
	typedef struct packed {
		logic [8:0] h;
		logic [6:0] s;
		logic [6:0] l;
	} pal_entry_t;

	// item travelling along the search chain
	typedef struct packed {
		logic [8:0]           h;
		logic [6:0]           s;
		logic [6:0]           l;
		logic [7:0]           best;
		logic [DIST_BITS-1:0] best_d;
	} cell_item_t;

	// shared divider request and response
	typedef struct packed {
		logic                 start;
		logic [DIVN_BITS-1:0] dividend;
		logic [7:0]           divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIVN_BITS-1:0] quot;
		logic                 rem_nz;
	} div_rsp_t;

	localparam pal_entry_t PAL_HSL [256] = '{
		'{0,0,0},'{0,100,25},'{120,100,25},'{60,100,25},'{240,100,25},'{300,100,25},
		'{180,100,25},'{0,0,75},
		'{0,0,50},'{0,100,50},'{120,100,50},'{60,100,50},'{240,100,50},'{300,100,50},
		'{180,100,50},'{0,0,100},
		'{0,0,0},'{240,99,18},'{240,100,26},'{240,100,34},'{240,100,42},'{240,100,50},
		'{120,99,18},'{180,99,18},
		'{205,99,18},'{230,99,18},'{255,99,18},'{281,99,18},'{120,100,26},'{162,100,26},
		'{180,100,26},'{197,100,26},
		'{215,100,26},'{233,100,26},'{120,100,34},'{152,100,34},'{166,100,34},'{180,100,34},
		'{193,100,34},'{207,100,34},
		'{120,100,42},'{146,100,42},'{157,100,42},'{168,100,42},'{180,100,42},'{191,100,42},
		'{120,100,50},'{142,100,50},
		'{151,100,50},'{161,100,50},'{170,100,50},'{180,100,50},'{0,99,18},'{300,99,18},
		'{282,100,26},'{272,100,34},
		'{266,100,42},'{262,100,50},'{60,99,18},'{0,0,37},'{240,17,45},'{240,33,52},
		'{240,60,60},'{240,100,68},
		'{77,100,26},'{120,17,45},'{180,17,45},'{240,17,45},'{300,17,45},'{359,17,45},
		'{87,100,34},'{120,33,52},
		'{150,33,52},'{180,33,52},'{210,33,52},'{240,33,52},'{93,100,42},'{120,60,60},
		'{140,60,60},'{160,60,60},
		'{180,60,60},'{200,60,60},'{97,100,50},'{120,100,68},'{135,100,68},'{150,100,68},
		'{165,100,68},'{180,100,68},
		'{0,100,26},'{317,100,26},'{300,100,26},'{286,100,34},'{277,100,42},'{271,100,50},
		'{142,17,45},'{0,17,45},
		'{300,17,45},'{270,33,52},'{260,60,60},'{255,100,68},'{60,100,26},'{60,17,45},
		'{0,0,52},'{240,20,60},
		'{240,50,68},'{240,100,76},'{73,100,34},'{90,33,52},'{120,20,60},'{180,20,60},
		'{240,20,60},'{300,20,60},
		'{82,100,42},'{100,60,60},'{120,50,68},'{150,50,68},'{180,50,68},'{210,50,68},
		'{88,100,50},'{105,100,68},
		'{120,100,76},'{140,100,76},'{160,100,76},'{180,100,76},'{0,100,34},'{327,100,34},
		'{313,100,34},'{300,100,34},
		'{288,100,42},'{281,100,50},'{71,33,52},'{0,33,52},'{330,33,52},'{300,33,52},
		'{280,60,60},'{270,100,68},
		'{202,20,60},'{60,20,60},'{0,20,60},'{300,20,60},'{270,50,68},'{260,100,76},
		'{60,100,34},'{60,33,52},
		'{60,20,60},'{0,0,68},'{240,33,76},'{240,100,84},'{71,100,42},'{80,60,60},
		'{90,50,68},'{120,33,76},
		'{180,33,76},'{240,33,76},'{78,100,50},'{90,100,68},'{100,100,76},'{120,100,84},
		'{150,100,84},'{180,100,84},
		'{0,100,42},'{333,100,42},'{322,100,42},'{311,100,42},'{300,100,42},'{290,100,50},
		'{47,60,60},'{0,60,60},
		'{340,60,60},'{320,60,60},'{300,60,60},'{285,100,68},'{101,50,68},'{30,50,68},
		'{0,50,68},'{330,50,68},
		'{300,50,68},'{280,100,76},'{262,33,76},'{120,33,76},'{60,33,76},'{0,33,76},
		'{300,33,76},'{270,100,84},
		'{60,100,42},'{60,60,60},'{60,50,68},'{60,33,76},'{0,0,84},'{240,100,92},
		'{69,100,50},'{75,100,68},
		'{80,100,76},'{90,100,84},'{120,100,92},'{180,100,92},'{0,100,50},'{337,100,50},
		'{328,100,50},'{318,100,50},
		'{309,100,50},'{300,100,50},'{35,100,68},'{0,100,68},'{345,100,68},'{330,100,68},
		'{315,100,68},'{300,100,68},
		'{67,100,76},'{20,100,76},'{0,100,76},'{340,100,76},'{320,100,76},'{300,100,76},
		'{131,100,84},'{60,100,84},
		'{30,100,84},'{0,100,84},'{330,100,84},'{300,100,84},'{322,100,92},'{180,100,92},
		'{120,100,92},'{60,100,92},
		'{0,100,92},'{300,100,92},'{60,100,50},'{60,100,68},'{60,100,76},'{60,100,84},
		'{60,100,92},'{0,0,100},
		'{0,0,3},'{0,0,7},'{0,0,10},'{0,0,14},'{0,0,18},'{0,0,22},'{0,0,26},'{0,0,30},
		'{0,0,34},'{0,0,38},'{0,0,42},'{0,0,46},'{0,0,50},'{0,0,54},'{0,0,58},'{0,0,61},
		'{0,0,65},'{0,0,69},'{0,0,73},'{0,0,77},'{0,0,81},'{0,0,85},'{0,0,89},'{0,0,93}
	};

	// x / 255 for x below 65280, by reciprocal with correction
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x >> 8) + 17'd1;
		return t[15:8];
	endfunction

endpackage

FILE: rtl/rtaq_div.sv
// Shared restoring divider, one quotient bit per cycle, 15-bit dividend by 8-bit divisor.
// Depends on rtaq_pkg.
module rtaq_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rtaq_pkg::div_req_t  req,
	output rtaq_pkg::div_rsp_t  rsp
);
	import rtaq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [3:0]           cnt_q;
	logic [7:0]           rem_q;
	logic [DIVN_BITS-1:0] quo_q;
	logic [7:0]           dvs_q;
	logic [8:0]           trial;
	logic                 qbit;
	logic [7:0]           rem_nx;

	// one restoring step
	always_comb begin
		trial  = {rem_q, quo_q[DIVN_BITS-1]};
		qbit   = (trial >= {1'b0, dvs_q});
		rem_nx = qbit ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(DIVN_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIVN_BITS-2:0], qbit};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = quo_q;
	assign rsp.rem_nz = |rem_q;

	// a new division may start in the cycle that reports the previous result
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a running division");

endmodule

FILE: rtl/rtaq_hsl.sv
// Front end: alpha scaling, max/min, and integer HSL using the shared divider.
// Depends on rtaq_pkg and rtaq_div.
module rtaq_hsl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           in_px,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rtaq_pkg::cell_item_t  out_item
);
	import rtaq_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCALE = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_HDIV  = 6'b001000,
		ST_SDIV  = 6'b010000,
		ST_OUT   = 6'b100000
	} hsl_state_t;

	hsl_state_t state_q;
	logic [7:0] red_q, green_q, blue_q, alpha_q;
	logic [7:0] r_q, g_q, b_q;
	logic       neg_q;
	logic [7:0] off_q;
	logic [DIVN_BITS-1:0] snum_q;
	logic [7:0] sden_q;
	logic [8:0] h_q;
	logic [6:0] s_q, l_q;

	div_req_t dreq;
	div_rsp_t drsp;

	// prep values
	logic [7:0] mx, mn, dlt, mag, dev;
	logic [8:0] sum;
	logic signed [8:0] diff;
	logic [7:0] off;
	logic [14:0] lt;
	logic [6:0] lum;
	logic grey;

	always_comb begin
		mx = r_q;
		mn = r_q;
		if (g_q > mx) mx = g_q;
		if (b_q > mx) mx = b_q;
		if (g_q < mn) mn = g_q;
		if (b_q < mn) mn = b_q;
		dlt  = mx - mn;
		sum  = {1'b0, mx} + {1'b0, mn};
		grey = (dlt == 8'd0);
		if (r_q == mx) begin
			diff = $signed({1'b0, g_q}) - $signed({1'b0, b_q});
			off  = 8'd0;
		end else if (g_q == mx) begin
			diff = $signed({1'b0, b_q}) - $signed({1'b0, r_q});
			off  = 8'd120;
		end else begin
			diff = $signed({1'b0, r_q}) - $signed({1'b0, g_q});
			off  = 8'd240;
		end
		mag = diff[8] ? 8'(-diff) : diff[7:0];
		dev = (sum >= 9'd255) ? 8'(sum - 9'd255) : 8'(9'd255 - sum);
		lt  = 15'(sum) * 15'd50;
		lum = 7'(div255(16'(lt)));
	end

	// hue finish: floor toward minus infinity, then wrap
	logic [6:0]         qmag;
	logic signed [10:0] hs;
	always_comb begin
		qmag = drsp.quot[6:0] + 7'(neg_q & drsp.rem_nz);
		hs   = neg_q ? $signed(11'(off_q)) - $signed(11'(qmag))
		             : $signed(11'(off_q)) + $signed(11'(qmag));
		if (hs < 0) hs = hs + 11'sd360;
	end

	// divider requests
	always_comb begin
		dreq = '0;
		if (state_q == ST_PREP && !grey) begin
			dreq.start    = 1'b1;
			dreq.dividend = DIVN_BITS'(mag) * DIVN_BITS'(60);
			dreq.divisor  = dlt;
		end else if (state_q == ST_HDIV && drsp.done) begin
			dreq.start    = 1'b1;
			dreq.dividend = snum_q;
			dreq.divisor  = sden_q;
		end
	end

	rtaq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_PREP;
				ST_PREP:  state_q <= grey ? ST_OUT : ST_HDIV;
				ST_HDIV:  if (drsp.done) state_q <= ST_SDIV;
				ST_SDIV:  if (drsp.done) state_q <= ST_OUT;
				ST_OUT:   if (out_ready) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			red_q   <= in_px[7:0];
			green_q <= in_px[15:8];
			blue_q  <= in_px[23:16];
			alpha_q <= in_px[31:24];
		end
		if (state_q == ST_SCALE) begin
			r_q <= div255(16'(red_q) * 16'(alpha_q));
			g_q <= div255(16'(green_q) * 16'(alpha_q));
			b_q <= div255(16'(blue_q) * 16'(alpha_q));
		end
		if (state_q == ST_PREP) begin
			neg_q  <= diff[8];
			off_q  <= off;
			snum_q <= DIVN_BITS'(dlt) * DIVN_BITS'(100);
			sden_q <= 8'd255 - dev;
			l_q    <= lum;
			h_q    <= '0;
			s_q    <= '0;
		end
		if (state_q == ST_HDIV && drsp.done) h_q <= hs[8:0];
		if (state_q == ST_SDIV && drsp.done) s_q <= drsp.quot[6:0];
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = (state_q == ST_OUT);
	assign out_item.h       = h_q;
	assign out_item.s       = s_q;
	assign out_item.l       = l_q;
	assign out_item.best    = '0;
	assign out_item.best_d  = '1;

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_HDIV || state_q == ST_SDIV))
		else $error("divider result with no division pending");

endmodule

FILE: rtl/rtaq_cell.sv
// One search cell: scans its group of palette entries and keeps the running best.
// Depends on rtaq_pkg.
module rtaq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rtaq_pkg::CELL_BITS-1:0] cell_id,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rtaq_pkg::cell_item_t       in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rtaq_pkg::cell_item_t       out_item
);
	import rtaq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	cell_item_t           item_q;

	logic [7:0]           idx;
	pal_entry_t           pe;
	logic signed [9:0]    dh;
	logic signed [7:0]    ds, dl;
	logic signed [19:0]   dh2;
	logic signed [15:0]   ds2, dl2;
	logic [DIST_BITS-1:0] cand_d;
	logic                 take;

	// distance to the entry under test
	always_comb begin
		idx    = {cell_id, cnt_q};
		pe     = PAL_HSL[idx];
		dh     = $signed({1'b0, item_q.h}) - $signed({1'b0, pe.h});
		ds     = $signed({1'b0, item_q.s}) - $signed({1'b0, pe.s});
		dl     = $signed({1'b0, item_q.l}) - $signed({1'b0, pe.l});
		dh2    = dh * dh;
		ds2    = ds * ds;
		dl2    = dl * dl;
		cand_d = DIST_BITS'(dh2) + DIST_BITS'(ds2) + DIST_BITS'(dl2);
		take   = busy_q && ({1'b0, idx} < 9'(PALETTE_SIZE)) && (cand_d < item_q.best_d);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_BITS'(1);
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && out_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	// running best, strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end else if (take) begin
			item_q.best   <= idx;
			item_q.best_d <= cand_d;
		end
	end

	assign in_ready  = !busy_q && !done_q;
	assign out_valid = done_q;
	assign out_item  = item_q;

	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("cell busy and done at once");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> busy_q && cnt_q == '0)
		else $error("cell did not start its scan");

endmodule

FILE: rtl/rgba_to_ansi256_quantizer_core.sv
// Path: front end with two 15-step divisions, then 16 search cells; grey items skip both divisions.
// Pacing: the front end takes a new item only after handing the last one on; the shared divider
// runs both divisions of an item; grey items need none and are paced by the scan and handoff of a cell.
// Reset: arst_n asynchronously clears all control state; the chain comes up empty.
// Top level: HSL front end, chain of search cells, output register.
// Depends on rtaq_pkg, rtaq_hsl, rtaq_cell.
module rgba_to_ansi256_quantizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // color_index
);
	import rtaq_pkg::*;

	logic       vld [NUM_CELLS+1];
	logic       rdy [NUM_CELLS+1];
	cell_item_t itm [NUM_CELLS+1];

	logic       out_valid_q;
	logic [7:0] out_data_q;

	rtaq_hsl u_hsl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_px     (s_axis_tdata),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_item  (itm[0])
	);

	// search chain, each cell owns a contiguous group of entries
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rtaq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (CELL_BITS'(i)),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_item   (itm[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_item  (itm[i+1])
		);
	end

	// output register
	assign rdy[NUM_CELLS] = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[NUM_CELLS]) begin
			out_valid_q <= vld[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NUM_CELLS] && vld[NUM_CELLS]) out_data_q <= itm[NUM_CELLS].best;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
